@@ rtl/core/cpg_pkg.sv @@
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants for the circle pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpg_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned RADIUS_BITS = 15;
  localparam int unsigned COLOR_BITS = 16;
  localparam int unsigned DEC_BITS = 21;
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned IDX_BITS = $clog2(GROUP_SIZE);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Midpoint decision constants
  localparam logic [DEC_BITS-1:0] DEC_INIT = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_INC_LO = DEC_BITS'(6);
  localparam logic [DEC_BITS-1:0] DEC_INC_HI = DEC_BITS'(10);

  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(GROUP_SIZE - 1);

  typedef enum logic [0:0] {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [DEC_BITS-1:0] dec_t;

  typedef struct packed {
    cmd_e                   command;
    coord_t                 center_x;
    coord_t                 center_y;
    logic [RADIUS_BITS-1:0] radius;
    color_t                 pen_color;
    logic                   fill;
  } cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_of_group;
    logic   figure_done;
  } pix_t;

  // One advance worth of work: offset pair plus context
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t ox;
    coord_t ov;
    color_t color;
    logic   done;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/core/cpg_if.sv @@
// ----------------------------------------------------------------------------
// cpg_if
// Valid/ready channels for command items and pixel items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpg_cmd_if;
  logic          valid;
  logic          ready;
  cpg_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cpg_pix_if;
  logic          valid;
  logic          ready;
  cpg_pkg::pix_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cpg_front.sv @@
// ----------------------------------------------------------------------------
// cpg_front
// Takes command items, keeps the midpoint state, queues one group per advance of an active figure.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cmd_valid_i,
  input  cpg_pkg::cmd_t            cmd_i,
  output logic                     cmd_ready_o,
  input  cpg_pkg::queue_status_t   q_status_i,
  output logic                     push_o,
  output cpg_pkg::group_t          group_o
);

  cpg_pkg::coord_t ccol_q, ccol_d;
  cpg_pkg::coord_t crow_q, crow_d;
  cpg_pkg::coord_t sx_q, sx_d;
  cpg_pkg::coord_t sy_q, sy_d;
  cpg_pkg::coord_t iy_q, iy_d;
  cpg_pkg::dec_t   dec_q, dec_d;
  cpg_pkg::color_t color_q, color_d;
  logic            fill_q, fill_d;
  logic            busy_q, busy_d;

  logic                              accept;
  logic                              inner_step;
  logic [cpg_pkg::COORD_BITS:0]      x_inc;   // x + 1, unsigned
  logic signed [cpg_pkg::COORD_BITS:0]   y_dec;   // y - 1, signed
  logic signed [cpg_pkg::COORD_BITS:0]   y_new;
  logic signed [cpg_pkg::COORD_BITS+1:0] x_cmp;
  logic signed [cpg_pkg::COORD_BITS+1:0] y_cmp;
  cpg_pkg::dec_t   x4;
  cpg_pkg::dec_t   y4;
  logic            done;

  assign cmd_ready_o = !q_status_i.full;
  assign accept      = cmd_valid_i && cmd_ready_o;

  always_comb begin
    x4    = cpg_pkg::DEC_BITS'({sx_q, 2'b00});
    y4    = cpg_pkg::DEC_BITS'({sy_q, 2'b00});
    x_inc = {1'b0, sx_q} + 1'b1;
    y_dec = $signed({1'b0, sy_q} - 1'b1);
    inner_step = fill_q && (iy_q < sy_q);
    y_new = dec_q[cpg_pkg::DEC_BITS-1] ? $signed({1'b0, sy_q}) : y_dec;
    x_cmp = $signed({1'b0, x_inc});
    y_cmp = {y_new[cpg_pkg::COORD_BITS], y_new};
    done  = !inner_step && (x_cmp > y_cmp);
  end

  always_comb begin
    ccol_d  = ccol_q;
    crow_d  = crow_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    iy_d    = iy_q;
    dec_d   = dec_q;
    color_d = color_q;
    fill_d  = fill_q;
    busy_d  = busy_q;
    push_o  = 1'b0;
    if (accept) begin
      case (cmd_i.command)
        cpg_pkg::CMD_START: begin
          ccol_d  = cmd_i.center_x;
          crow_d  = cmd_i.center_y;
          color_d = cmd_i.pen_color;
          fill_d  = cmd_i.fill;
          sx_d    = '0;
          sy_d    = cpg_pkg::COORD_BITS'(cmd_i.radius);
          iy_d    = '0;
          dec_d   = cpg_pkg::DEC_INIT - cpg_pkg::DEC_BITS'({cmd_i.radius, 1'b0});
          busy_d  = 1'b1;
        end
        cpg_pkg::CMD_ADVANCE: begin
          if (busy_q) begin
            push_o = 1'b1;
            if (inner_step) begin
              iy_d = iy_q + 1'b1;
            end else begin
              if (dec_q[cpg_pkg::DEC_BITS-1]) begin
                dec_d = dec_q + x4 + cpg_pkg::DEC_INC_LO;
              end else begin
                dec_d = dec_q + x4 - y4 + cpg_pkg::DEC_INC_HI;
              end
              sx_d = x_inc[cpg_pkg::COORD_BITS-1:0];
              sy_d = y_new[cpg_pkg::COORD_BITS-1:0];
              iy_d = x_inc[cpg_pkg::COORD_BITS-1:0];
              if (done) begin
                busy_d = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    group_o.cx    = ccol_q;
    group_o.cy    = crow_q;
    group_o.ox    = sx_q;
    group_o.ov    = fill_q ? iy_q : sy_q;
    group_o.color = color_q;
    group_o.done  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccol_q  <= '0;
      crow_q  <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      iy_q    <= '0;
      dec_q   <= '0;
      color_q <= '0;
      fill_q  <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      ccol_q  <= ccol_d;
      crow_q  <= crow_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      iy_q    <= iy_d;
      dec_q   <= dec_d;
      color_q <= color_d;
      fill_q  <= fill_d;
      busy_q  <= busy_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cpg_queue.sv @@
// ----------------------------------------------------------------------------
// cpg_queue
// Short FIFO of pending groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_queue (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  cpg_pkg::group_t         group_i,
  input  wire                     pop_i,
  output cpg_pkg::group_t         group_o,
  output cpg_pkg::queue_status_t  status_o
);

  cpg_pkg::group_t mem_q [cpg_pkg::QUEUE_DEPTH];
  logic [cpg_pkg::QPTR_BITS-1:0] wr_q, rd_q;
  logic [cpg_pkg::QCNT_BITS-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign status_o.full  = (cnt_q == cpg_pkg::QCNT_BITS'(cpg_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign group_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cpg_back.sv @@
// ----------------------------------------------------------------------------
// cpg_back
// Expands each queued group into eight mirrored pixels, one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cpg_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  cpg_pkg::group_t         group_i,
  input  cpg_pkg::queue_status_t  q_status_i,
  output logic                    pop_o,
  output logic                    pix_valid_o,
  output cpg_pkg::pix_t           pix_o,
  input  wire                     pix_ready_i
);

  cpg_pkg::group_t               grp_q;
  logic                          grp_vld_q, grp_vld_d;
  logic [cpg_pkg::IDX_BITS-1:0]  idx_q;
  cpg_pkg::pix_t                 out_q, pix_d;
  logic                          out_vld_q, out_vld_d;
  logic                          load, grp_end;
  cpg_pkg::coord_t               a, b;

  assign load    = grp_vld_q && (!out_vld_q || pix_ready_i);
  assign grp_end = load && (idx_q == cpg_pkg::IDX_LAST);
  assign pop_o   = (!grp_vld_q || grp_end) && !q_status_i.empty;

  // idx bit 2 swaps the pair, bit 0 negates the column term, bit 1 the row term
  always_comb begin
    a = idx_q[2] ? grp_q.ov : grp_q.ox;
    b = idx_q[2] ? grp_q.ox : grp_q.ov;
    pix_d.pixel_x       = idx_q[0] ? (grp_q.cx - a) : (grp_q.cx + a);
    pix_d.pixel_y       = idx_q[1] ? (grp_q.cy - b) : (grp_q.cy + b);
    pix_d.pixel_color   = grp_q.color;
    pix_d.last_of_group = (idx_q == cpg_pkg::IDX_LAST);
    pix_d.figure_done   = grp_q.done && (idx_q == cpg_pkg::IDX_LAST);
  end

  always_comb begin
    grp_vld_d = grp_vld_q;
    if (pop_o) begin
      grp_vld_d = 1'b1;
    end else if (grp_end) begin
      grp_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (pix_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      grp_q <= group_i;
    end
    if (load) begin
      out_q <= pix_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      grp_vld_q <= grp_vld_d;
      out_vld_q <= out_vld_d;
      if (load) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign pix_valid_o = out_vld_q;
  assign pix_o       = out_q;

endmodule

`default_nettype wire

@@ rtl/core/circle_pixel_generator_unit.sv @@
// ----------------------------------------------------------------------------
// circle_pixel_generator_unit
// Midpoint circle rasterizer with eight-way symmetry.
// ----------------------------------------------------------------------------
// A start item latches center, color and fill mode and primes the midpoint
// decision with 3 - 2r; it produces no pixel. Each advance item while a figure
// is active produces eight pixel items in the fixed mirror order
// (+x,+v) (-x,+v) (+x,-v) (-x,-v) (+v,+x) (-v,+x) (+v,-x) (-v,-x), with
// last_of_group on the eighth and figure_done on the eighth pixel of the final
// advance. In fill mode v sweeps from x up to y over successive advances
// before x moves. Advances while idle are dropped silently. Coordinates wrap
// modulo 2^16. Throughput: the pixel port emits one item per cycle while the
// sink is ready; command items are taken one per cycle until the two-entry
// group queue fills, and start items never wait on the pixel side unless that
// queue is full. With the back idle and the queue empty, the first pixel of an
// advance passes through the group queue, the back's group register and its
// output register before it is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_pixel_generator_unit (
  input  wire            clk_i,
  input  wire            rst_ni,
  cpg_cmd_if.sink        cmd_i,
  cpg_pix_if.source      pix_o
);

  cpg_pkg::group_t        front_group;
  cpg_pkg::group_t        queue_group;
  cpg_pkg::queue_status_t q_status;
  logic                   push;
  logic                   pop;

  // Front: command decode and midpoint state update, one item per cycle while the queue is not full
  cpg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_i       (cmd_i.payload),
    .cmd_ready_o (cmd_i.ready),
    .q_status_i  (q_status),
    .push_o      (push),
    .group_o     (front_group)
  );

  // Queue of offset pairs waiting for expansion
  cpg_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .group_i  (front_group),
    .pop_i    (pop),
    .group_o  (queue_group),
    .status_o (q_status)
  );

  // Back: eight-way mirror, registered pixel output
  cpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .group_i     (queue_group),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .pix_valid_o (pix_o.valid),
    .pix_o       (pix_o.payload),
    .pix_ready_i (pix_o.ready)
  );

  // A group only enters when the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("group pushed into full queue");

  // figure_done only ever marks the closing pixel of a group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      pix_o.valid && pix_o.payload.figure_done |-> pix_o.payload.last_of_group)
    else $error("figure_done outside group end");

  // An idle queue with no pending pop keeps the back from inventing work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ tb/tb_circle_pixel_generator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_circle_pixel_generator_unit
// Self-checking bench for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
// Command items are planned up front in a queue. The plan opens with a short
// directed prelude: an advance with no figure active, a zero radius, wrapping
// centers at both ends of the coordinate range, the largest radius, fill and
// outline modes, and a restart in the middle of a figure. It then continues
// with random figures. Most figures run to completion; some are cut short by
// a fresh start, and some are followed by advances that should be dropped.
// A clocked driver offers the planned items. On each accepted item it updates
// a local midpoint model and queues the pixels, if any, that item should produce.
// A clocked monitor checks every accepted pixel against the oldest queued one.
// Both sides idle in random bursts. The sink also holds off once for a long
// stretch, so the group queue fills and stalls the command port. The source
// pauses once until every queued pixel has drained.
// ----------------------------------------------------------------------------

module tb_circle_pixel_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RST_CYCLES    = 3;
  localparam int unsigned RANDOM_ITEMS  = 480;
  localparam int unsigned CALM_TAIL     = 80;     // last items run with no idling
  localparam int unsigned HOLD_AT       = 60;     // accepted count that starts the long hold
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    cpg_pkg::cmd_t item;
    bit            drain_first;    // hold this item back until no pixel is pending
  } cmd_plan_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cpg_cmd_if cmd_ch ();
  cpg_pix_if pix_ch ();

  circle_pixel_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .pix_o  (pix_ch)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Midpoint model: state as it stands after every accepted command item
  // --------------------------------------------------------------------------
  cpg_pkg::coord_t                     ctr_col       = '0;
  cpg_pkg::coord_t                     ctr_row       = '0;
  cpg_pkg::coord_t                     off_x         = '0;
  cpg_pkg::coord_t                     off_y         = '0;
  cpg_pkg::coord_t                     sweep_v       = '0;  // inner index in fill mode
  logic signed [cpg_pkg::DEC_BITS-1:0] midpt_err     = '0;
  cpg_pkg::color_t                     pen           = '0;
  logic                                disc_mode     = 1'b0;
  logic                                figure_active = 1'b0;

  cmd_plan_t     cmd_plan [$];
  cpg_pkg::pix_t pixels_due [$];

  int unsigned n_starts   = 0;
  int unsigned n_advances = 0;   // advances that plotted something
  int unsigned n_pixels   = 0;
  int unsigned n_figures  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_cycles   = 0;

  int          src_gap;
  int          snk_gap;
  int unsigned taken;            // command items accepted so far
  int unsigned hold_left;
  logic        calm;
  logic        jitter_on;

  // Idling stays off for every third band of 40 items and in the tail.
  assign jitter_on = !calm && ((taken / 40) % 3 != 2);

  // Apply one accepted command item and queue the pixels it should produce.
  task automatic rasterize_cmd(input cpg_pkg::cmd_t c);
    cpg_pkg::coord_t ox;
    cpg_pkg::coord_t ov;
    cpg_pkg::coord_t col_at [cpg_pkg::GROUP_SIZE];
    cpg_pkg::coord_t row_at [cpg_pkg::GROUP_SIZE];
    int              x;
    int              y;
    int              err;
    logic            fin;
    cpg_pkg::pix_t   p;
    if (c.command == cpg_pkg::CMD_START) begin
      // a start always begins a new figure, even mid-figure; no pixel
      ctr_col       = c.center_x;
      ctr_row       = c.center_y;
      pen           = c.pen_color;
      disc_mode     = c.fill;
      off_x         = '0;
      off_y         = cpg_pkg::coord_t'(c.radius);
      sweep_v       = '0;
      err           = 3 - 2 * int'(c.radius);
      midpt_err     = err[cpg_pkg::DEC_BITS-1:0];
      figure_active = 1'b1;
      n_starts++;
      return;
    end
    if (!figure_active)
      return;  // advance with nothing active is dropped

    n_advances++;
    ox  = off_x;
    ov  = disc_mode ? sweep_v : off_y;
    x   = int'(off_x);
    y   = int'(off_y);
    fin = 1'b0;

    if (disc_mode && int'(sweep_v) < y) begin
      sweep_v = sweep_v + 1'b1;
    end else begin
      if (midpt_err < 0) begin
        err = int'(midpt_err) + 4 * x + 6;
      end else begin
        err = int'(midpt_err) + 4 * (x - y) + 10;
        y--;
      end
      midpt_err = err[cpg_pkg::DEC_BITS-1:0];
      x++;
      fin     = (x > y);   // signed: y stepping below zero still ends it
      off_x   = x[cpg_pkg::COORD_BITS-1:0];
      off_y   = y[cpg_pkg::COORD_BITS-1:0];
      sweep_v = off_x;
      if (fin)
        figure_active = 1'b0;
    end

    // eight-way mirror order, coordinates wrap at 16 bits
    col_at = '{ctr_col + ox, ctr_col - ox, ctr_col + ox, ctr_col - ox,
               ctr_col + ov, ctr_col - ov, ctr_col + ov, ctr_col - ov};
    row_at = '{ctr_row + ov, ctr_row + ov, ctr_row - ov, ctr_row - ov,
               ctr_row + ox, ctr_row + ox, ctr_row - ox, ctr_row - ox};
    for (int k = 0; k < cpg_pkg::GROUP_SIZE; k++) begin
      p.pixel_x       = col_at[k];
      p.pixel_y       = row_at[k];
      p.pixel_color   = pen;
      p.last_of_group = (k == cpg_pkg::GROUP_SIZE - 1);
      p.figure_done   = fin && (k == cpg_pkg::GROUP_SIZE - 1);
      pixels_due.push_back(p);
    end
  endtask

  // Queue one command item; advances carry random don't-care fields.
  function automatic void plan_cmd(input cpg_pkg::cmd_e op, input cpg_pkg::coord_t cx,
                                   input cpg_pkg::coord_t cy,
                                   input logic [cpg_pkg::RADIUS_BITS-1:0] r,
                                   input cpg_pkg::color_t col,
                                   input logic fl, input bit drain);
    cmd_plan_t e;
    e.item.command   = op;
    e.item.center_x  = cx;
    e.item.center_y  = cy;
    e.item.radius    = r;
    e.item.pen_color = col;
    e.item.fill      = fl;
    if (op == cpg_pkg::CMD_ADVANCE) begin
      e.item.center_x  = cpg_pkg::coord_t'($urandom);
      e.item.center_y  = cpg_pkg::coord_t'($urandom);
      e.item.radius    = cpg_pkg::RADIUS_BITS'($urandom);
      e.item.pen_color = cpg_pkg::color_t'($urandom);
      e.item.fill      = 1'($urandom);
    end
    e.drain_first = drain;
    cmd_plan.push_back(e);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers planned items, holds each until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_plan_t nxt;
    if (!rst_ni) begin
      cmd_ch.valid   <= 1'b0;
      cmd_ch.payload <= '0;
      src_gap        <= 0;
      calm           <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        rasterize_cmd(cmd_ch.payload);
      calm <= (cmd_plan.size() < CALM_TAIL);

      if (cmd_ch.valid && !cmd_ch.ready) begin
        // item still waiting: keep it on the bus
      end else if (src_gap != 0) begin
        src_gap      <= src_gap - 1;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_plan.size() == 0 ||
                   (cmd_plan[0].drain_first && pixels_due.size() != 0)) begin
        cmd_ch.valid <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 7) == 0) begin
        src_gap      <= $urandom_range(0, 17);
        cmd_ch.valid <= 1'b0;
      end else begin
        nxt            = cmd_plan.pop_front();
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= nxt.item;
      end
    end
  end

  // Long sink hold-off, started once a fixed number of items has gone in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken     <= 0;
      hold_left <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        taken <= taken + 1;
      if (cmd_ch.valid && cmd_ch.ready && taken == HOLD_AT)
        hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
        hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted pixel against the oldest queued one
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    cpg_pkg::pix_t want;
    cpg_pkg::pix_t got;
    if (!rst_ni) begin
      pix_ch.ready <= 1'b0;
      snk_gap      <= 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        got = pix_ch.payload;
        n_pixels++;
        if (pixels_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] unexpected pixel x=%h y=%h c=%h last=%b done=%b", $realtime,
                     got.pixel_x, got.pixel_y, got.pixel_color, got.last_of_group,
                     got.figure_done);
        end else begin
          want = pixels_due.pop_front();
          if (want.figure_done)
            n_figures++;
          if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
              got.pixel_color !== want.pixel_color ||
              got.last_of_group !== want.last_of_group ||
              got.figure_done !== want.figure_done) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("[%0t] pixel mismatch: exp x=%h y=%h c=%h l=%b d=%b",
                       $realtime, want.pixel_x, want.pixel_y, want.pixel_color,
                       want.last_of_group, want.figure_done,
                       ", got x=%h y=%h c=%h l=%b d=%b", got.pixel_x, got.pixel_y,
                       got.pixel_color, got.last_of_group, got.figure_done);
          end
        end
      end

      if (snk_gap != 0) begin
        snk_gap      <= snk_gap - 1;
        pix_ch.ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 7) == 0) begin
        snk_gap      <= $urandom_range(0, 17);
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= (hold_left == 0);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", n_cycles,
               pixels_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int          pick;
    int          r;
    int          x;
    int          y;
    int          d;
    int          v;
    int          steps;
    int          n_adv;
    int unsigned n_live;
    logic        fl;
    bit          first;

    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    pix_ch.ready   = 1'b0;
    rst_ni         = 1'b0;

    // directed prelude
    plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);               // nothing active
    plan_cmd(cpg_pkg::CMD_START, 16'h0000, 16'h0000, 15'd0, 16'hFFFF, 1'b0, 0); // zero r
    plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);               // center x8, done
    plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);               // idle again
    plan_cmd(cpg_pkg::CMD_START, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'h0000, 1'b1, 0); // max r
    plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);
    plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);
    plan_cmd(cpg_pkg::CMD_START, 16'h5555, 16'hAAAA, 15'h2AAA, 16'hAAAA, 1'b0, 0); // restart
    plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);
    plan_cmd(cpg_pkg::CMD_START, 16'hAAAA, 16'h5555, 15'h5555, 16'h5555, 1'b1, 0);
    plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);
    plan_cmd(cpg_pkg::CMD_START, 16'h0000, 16'h0000, 15'd3, 16'h1234, 1'b0, 0); // neg wrap
    repeat (4) plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);   // 3 live + 1 idle
    plan_cmd(cpg_pkg::CMD_START, 16'h0001, 16'hFFFE, 15'd2, 16'hC3C3, 1'b1, 0); // small disc
    repeat (7) plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);   // 5 live + 2 idle

    // random figures: mostly complete, some cut short, some trailed by noise
    n_live = 0;
    first  = 1'b1;
    while (n_live < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        r = $urandom_range(0, 8);
      else if (pick < 95)
        r = $urandom_range(9, 16);
      else
        r = $urandom_range(0, 32767);
      fl = 1'($urandom);

      if (r > 16) begin
        steps = $urandom_range(1, 4);  // huge figure: only its first groups
      end else begin
        x     = 0;
        y     = r;
        d     = 3 - 2 * r;
        v     = 0;
        steps = 0;
        do begin
          steps++;
          if (fl && v < y) begin
            v++;
          end else begin
            if (d < 0) begin
              d += 4 * x + 6;
            end else begin
              d += 4 * (x - y) + 10;
              y--;
            end
            x++;
            v = x;
          end
        end while (x <= y);
      end

      n_adv = steps;
      if ($urandom_range(0, 4) == 0)
        n_adv = $urandom_range(0, steps - 1);  // broken: next start cuts in

      plan_cmd(cpg_pkg::CMD_START, cpg_pkg::coord_t'($urandom), cpg_pkg::coord_t'($urandom),
               cpg_pkg::RADIUS_BITS'(r), cpg_pkg::color_t'($urandom), fl, first);
      first = 1'b0;
      repeat (n_adv) plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);
      n_live += 1 + n_adv;

      if (n_adv == steps && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) plan_cmd(cpg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0);
    end

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_plan.size() != 0 || cmd_ch.valid) @(posedge clk_i);
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d starts and %0d plotting advances (idle, restart, wrap, fill)",
             n_starts, n_advances);
    $display("checked %0d pixels over %0d finished figures, %0d mismatches",
             n_pixels, n_figures, n_errors);
    if (n_errors == 0 && pixels_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
